// File: rtl/sem_pkg.sv
// Shared types, constants and helper functions of the Sobel edge magnitude block.
`default_nettype none
package sem_pkg;
    localparam int CFG_W          = 11;
    localparam int IDX_W          = 1;
    localparam int CH_W           = 8;
    localparam int NUM_CH         = 3;
    localparam int PIX_W          = CH_W * NUM_CH;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT     = 1024;
    localparam int GRAD_W         = 12;
    localparam int SQ_W           = 20;
    localparam int SUM_W          = 21;
    localparam int ROOT_IN_W      = 16;

    localparam logic [CFG_W-1:0]     RESET_DIM = 11'd1024;
    localparam logic [ROOT_IN_W-1:0] SAT_LIMIT = 16'd65280;
    localparam logic [CH_W-1:0]      MAG_MAX   = 8'd255;

    typedef enum logic [IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_reg_idx;

    // 3x3 neighborhood of one channel, row major, top row first
    typedef logic [8:0][CH_W-1:0] t_win_ch;

    typedef struct packed {
        logic            done;
        logic [CH_W-1:0] mag;
    } t_lane_out;

    function automatic logic signed [GRAD_W-1:0] pix_s(input logic [CH_W-1:0] p);
        pix_s = $signed({{(GRAD_W-CH_W){1'b0}}, p});
    endfunction

    // Gx = {-1,0,1,-2,0,2,-1,0,1}
    function automatic logic signed [GRAD_W-1:0] grad_x(input t_win_ch p);
        grad_x = pix_s(p[2]) - pix_s(p[0]) + (pix_s(p[5]) <<< 1) - (pix_s(p[3]) <<< 1)
               + pix_s(p[8]) - pix_s(p[6]);
    endfunction

    // Gy = {-1,-2,-1,0,0,0,1,2,1}
    function automatic logic signed [GRAD_W-1:0] grad_y(input t_win_ch p);
        grad_y = pix_s(p[6]) + (pix_s(p[7]) <<< 1) + pix_s(p[8])
               - pix_s(p[0]) - (pix_s(p[1]) <<< 1) - pix_s(p[2]);
    endfunction

    // zero acts as one, values above the limit act as the limit
    function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v,
                                                 input int unsigned lim);
        logic [CFG_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = CFG_W'(1);
        end else if (32'(v) > lim) begin
            r = CFG_W'(lim);
        end
        eff_dim = r;
    endfunction
endpackage
`default_nettype wire

// File: rtl/sem_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sem_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// File: rtl/sem_lane.sv
// One channel lane: gradients, squares and a bit-serial rounded square root.
`default_nettype none
module sem_lane (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire sem_pkg::t_win_ch  i_pix,
    output sem_pkg::t_lane_out     o_res
);
    typedef enum logic [4:0] {
        L_IDLE = 5'b00001,
        L_SQ   = 5'b00010,
        L_SUM  = 5'b00100,
        L_ROOT = 5'b01000,
        L_RND  = 5'b10000
    } t_lane_st;

    t_lane_st                                r_st;
    logic signed [sem_pkg::GRAD_W-1:0]       r_gx, r_gy;
    logic        [sem_pkg::SQ_W-1:0]         r_sqx, r_sqy;
    logic        [sem_pkg::ROOT_IN_W-1:0]    r_s;
    logic                                    r_sat;
    logic        [sem_pkg::CH_W-1:0]         r_q, r_bit, r_mag;
    logic                                    r_done;

    logic signed [2*sem_pkg::GRAD_W-1:0]     sqx_full, sqy_full;
    logic        [sem_pkg::SUM_W-1:0]        sum;
    logic        [sem_pkg::CH_W-1:0]         t_try;
    logic        [2*sem_pkg::CH_W-1:0]       t_sq;
    logic        [2*sem_pkg::CH_W-1:0]       q_sq;
    logic        [2*sem_pkg::CH_W:0]         q_sq_q;

    assign sqx_full = r_gx * r_gx;
    assign sqy_full = r_gy * r_gy;
    assign sum      = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign t_try    = r_q | r_bit;
    assign t_sq     = t_try * t_try;
    assign q_sq     = r_q * r_q;
    assign q_sq_q   = {1'b0, q_sq} + {{(sem_pkg::CH_W+1){1'b0}}, r_q};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= L_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_st)
                L_IDLE: begin
                    if (i_start) begin
                        r_gx <= sem_pkg::grad_x(i_pix);
                        r_gy <= sem_pkg::grad_y(i_pix);
                        r_st <= L_SQ;
                    end
                end
                L_SQ: begin
                    r_sqx <= sqx_full[sem_pkg::SQ_W-1:0];
                    r_sqy <= sqy_full[sem_pkg::SQ_W-1:0];
                    r_st  <= L_SUM;
                end
                L_SUM: begin
                    r_sat <= sum > {{(sem_pkg::SUM_W-sem_pkg::ROOT_IN_W){1'b0}},
                                    sem_pkg::SAT_LIMIT};
                    r_s   <= sum[sem_pkg::ROOT_IN_W-1:0];
                    r_q   <= '0;
                    r_bit <= {1'b1, {(sem_pkg::CH_W-1){1'b0}}};
                    r_st  <= L_ROOT;
                end
                L_ROOT: begin
                    // one result bit per cycle, most significant first
                    if (t_sq <= r_s) begin
                        r_q <= t_try;
                    end
                    r_bit <= r_bit >> 1;
                    if (r_bit[0]) begin
                        r_st <= L_RND;
                    end
                end
                L_RND: begin
                    if (r_sat) begin
                        r_mag <= sem_pkg::MAG_MAX;
                    end else if ({1'b0, r_s} > q_sq_q) begin
                        r_mag <= r_q + 1'b1;
                    end else begin
                        r_mag <= r_q;
                    end
                    r_done <= 1'b1;
                    r_st   <= L_IDLE;
                end
                default: r_st <= L_IDLE;
            endcase
        end
    end

    assign o_res.done = r_done;
    assign o_res.mag  = r_mag;
endmodule
`default_nettype wire

// File: rtl/sobel_edge_magnitude_core.sv
// Top level of the streaming RGB Sobel edge magnitude block.
`default_nettype none
// Streaming 3x3 Sobel edge magnitude on RGB pixels sent in raster order. Each
// channel gets round(sqrt(Gx^2+Gy^2)) saturated at 255, with neighbors outside
// the image counted as zero. A result leaves one row plus one pixel after its
// pixel enters, so after a frame send image_width+1 drain requests (cmd = 1);
// frame_last marks the final result of the frame. A request that yields a
// result runs from its accept to the next accept through these steps: the line
// store read and window update, handing the masked window to the lanes, the
// three channel lanes running side by side (square, sum, square root at one
// bit per cycle, rounding), seeing the lanes finish and the merge stage loading
// the output register; a result still stalled in the output register holds the
// merge stage until it leaves. A request that yields no result (the first row
// and first pixel of the next row of a frame) ends after the line store read
// and window update. A new request is taken while a finished result still
// waits in the output register. The two line stores are RAMs of MAX_WIDTH
// entries with no clearing pass: entries left from an earlier frame are read
// but reach only window taps that the edge masks zero. Writing either register
// restarts the frame; write only while idle.
module sobel_edge_magnitude_core #(
    parameter int MAX_WIDTH = sem_pkg::DEF_MAX_WIDTH
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic                        i_cmd,
    input  wire logic [sem_pkg::CH_W-1:0]    i_red,
    input  wire logic [sem_pkg::CH_W-1:0]    i_green,
    input  wire logic [sem_pkg::CH_W-1:0]    i_blue,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic      [sem_pkg::CH_W-1:0]    o_red_edge,
    output logic      [sem_pkg::CH_W-1:0]    o_green_edge,
    output logic      [sem_pkg::CH_W-1:0]    o_blue_edge,
    output logic                             o_frame_last,
    input  wire logic                        i_cfg_we,
    input  wire logic [sem_pkg::IDX_W-1:0]   i_cfg_index,
    input  wire logic [sem_pkg::CFG_W-1:0]   i_cfg_data
);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = sem_pkg::CFG_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_RD    = 5'b00010,
        S_WIN   = 5'b00100,
        S_CALC  = 5'b01000,
        S_MERGE = 5'b10000
    } t_state;

    t_state                         r_state;
    logic [CW-1:0]                  r_width_cfg, r_height_cfg;
    logic [CW-1:0]                  r_in_row, r_in_col, r_out_row, r_out_col;
    logic [CW-1:0]                  r_col;
    logic [sem_pkg::PIX_W-1:0]      r_px;
    logic                           r_emit;
    logic                           r_last;
    logic [8:0][sem_pkg::PIX_W-1:0] r_win;
    logic                           r_ovalid;
    logic [sem_pkg::CH_W-1:0]       r_red, r_green, r_blue;
    logic                           r_olast;

    logic [CW-1:0]                  w_eff, h_eff;
    logic                           in_acc, out_acc;
    logic                           merge_fire;
    logic [CW-1:0]                  col_clamp;
    logic [CW:0]                    col_next;
    logic [sem_pkg::PIX_W-1:0]      up_rd, mid_rd;
    logic [AW-1:0]                  ram_addr;
    logic [CW:0]                    orow_p1, ocol_p1;
    logic                           use_top, use_bot, use_lft, use_rgt, last_px;
    logic [8:0]                     use_k;
    logic                           start_lanes;
    sem_pkg::t_lane_out             lane_res [sem_pkg::NUM_CH];
    logic                           lanes_done;

    assign w_eff = sem_pkg::eff_dim(r_width_cfg, MAX_WIDTH);
    assign h_eff = sem_pkg::eff_dim(r_height_cfg, sem_pkg::MAX_HEIGHT);

    // take a request only between items and never during reset
    assign o_stall = (r_state != S_IDLE) || !i_rst_n;
    assign in_acc  = i_valid && !o_stall;
    assign out_acc = r_ovalid && !i_stall;

    // merge once the output register is free or empties this cycle
    assign merge_fire = (r_state == S_MERGE) && (!r_ovalid || out_acc);

    assign col_clamp = (r_in_col >= w_eff) ? (w_eff - 1'b1) : r_in_col;
    assign col_next  = {1'b0, r_col} + 1'b1;
    assign ram_addr  = (r_state == S_IDLE) ? AW'(col_clamp) : AW'(r_col);

    // both line stores share one column address: read at accept, write back next
    sem_ram #(.WIDTH(sem_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
        .i_clk   (i_clk),
        .i_we    (r_state == S_RD),
        .i_waddr (ram_addr),
        .i_wdata (mid_rd),
        .i_re    (in_acc),
        .i_raddr (ram_addr),
        .o_rdata (up_rd)
    );

    sem_ram #(.WIDTH(sem_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
        .i_clk   (i_clk),
        .i_we    (r_state == S_RD),
        .i_waddr (ram_addr),
        .i_wdata (r_px),
        .i_re    (in_acc),
        .i_raddr (ram_addr),
        .o_rdata (mid_rd)
    );

    // neighbor masks at the output position
    assign orow_p1 = {1'b0, r_out_row} + 1'b1;
    assign ocol_p1 = {1'b0, r_out_col} + 1'b1;
    assign use_top = (r_out_row != '0);
    assign use_bot = (orow_p1 < {1'b0, h_eff});
    assign use_lft = (r_out_col != '0);
    assign use_rgt = (ocol_p1 < {1'b0, w_eff});
    assign last_px = !use_bot && !use_rgt;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            use_k[k] = !((k / 3 == 0) && !use_top) && !((k / 3 == 2) && !use_bot)
                    && !((k % 3 == 0) && !use_lft) && !((k % 3 == 2) && !use_rgt);
        end
    end

    assign start_lanes = (r_state == S_WIN);

    // one lane per color channel, red first
    for (genvar c = 0; c < sem_pkg::NUM_CH; c++) begin : g_lane
        sem_pkg::t_win_ch lane_pix;
        always_comb begin
            for (int k = 0; k < 9; k++) begin
                lane_pix[k] = use_k[k] ?
                    r_win[k][(sem_pkg::NUM_CH-1-c)*sem_pkg::CH_W +: sem_pkg::CH_W] : '0;
            end
        end
        sem_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (start_lanes),
            .i_pix   (lane_pix),
            .o_res   (lane_res[c])
        );
    end

    // lanes run in lockstep
    always_comb begin
        lanes_done = 1'b1;
        for (int c = 0; c < sem_pkg::NUM_CH; c++) begin
            lanes_done = lanes_done && lane_res[c].done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_width_cfg  <= sem_pkg::RESET_DIM;
            r_height_cfg <= sem_pkg::RESET_DIM;
            r_in_row     <= '0;
            r_in_col     <= '0;
            r_out_row    <= '0;
            r_out_col    <= '0;
            r_win        <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            if (merge_fire) begin
                r_ovalid <= 1'b1;
            end else if (out_acc) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                // a register write discards the frame in flight
                unique case (sem_pkg::t_reg_idx'(i_cfg_index))
                    sem_pkg::REG_IMAGE_WIDTH:  r_width_cfg  <= i_cfg_data;
                    sem_pkg::REG_IMAGE_HEIGHT: r_height_cfg <= i_cfg_data;
                    default: ;
                endcase
                r_in_row  <= '0;
                r_in_col  <= '0;
                r_out_row <= '0;
                r_out_col <= '0;
                r_win     <= '0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_col  <= col_clamp;
                        r_px   <= (i_cmd || r_in_row >= h_eff) ? '0
                                  : {i_red, i_green, i_blue};
                        r_emit <= (r_in_row >= CW'(2)) ||
                                  (r_in_row == CW'(1) && col_clamp != '0);
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    // shift the window left and bring in the new column
                    for (int r = 0; r < 3; r++) begin
                        r_win[r*3]   <= r_win[r*3+1];
                        r_win[r*3+1] <= r_win[r*3+2];
                    end
                    r_win[2] <= up_rd;
                    r_win[5] <= mid_rd;
                    r_win[8] <= r_px;
                    if (col_next >= {1'b0, w_eff}) begin
                        r_in_col <= '0;
                        if (r_in_row != {CW{1'b1}}) begin
                            r_in_row <= r_in_row + 1'b1;
                        end
                    end else begin
                        r_in_col <= col_next[CW-1:0];
                    end
                    r_state <= r_emit ? S_WIN : S_IDLE;
                end
                S_WIN: begin
                    // lanes capture the masked window at this edge
                    r_last <= last_px;
                    if (last_px) begin
                        r_in_row  <= '0;
                        r_in_col  <= '0;
                        r_out_row <= '0;
                        r_out_col <= '0;
                        r_win     <= '0;
                    end else if (ocol_p1 >= {1'b0, w_eff}) begin
                        r_out_col <= '0;
                        r_out_row <= orow_p1[CW-1:0];
                    end else begin
                        r_out_col <= ocol_p1[CW-1:0];
                    end
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    if (lanes_done) begin
                        r_state <= S_MERGE;
                    end
                end
                S_MERGE: begin
                    // hold until the output register is free
                    if (merge_fire) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (merge_fire) begin
            r_red   <= lane_res[0].mag;
            r_green <= lane_res[1].mag;
            r_blue  <= lane_res[2].mag;
            r_olast <= r_last;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_red_edge   = r_red;
    assign o_green_edge = r_green;
    assign o_blue_edge  = r_blue;
    assign o_frame_last = r_olast;
endmodule
`default_nettype wire

// File: rtl/sem_checker.sv
// Port-level checker for the Sobel edge magnitude block, with its bind.
`default_nettype none
module sem_checker (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     i_valid,
    input wire logic                     o_stall,
    input wire logic                     o_valid,
    input wire logic                     i_stall,
    input wire logic [sem_pkg::CH_W-1:0] o_red_edge,
    input wire logic                     o_frame_last
);
    // a finished result stays offered while stalled
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_red_edge) && $stable(o_frame_last))
        else $error("stalled result changed");

    // one request at a time: the cycle after an accept stalls
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second request taken back to back");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result offered after reset");
endmodule

bind sobel_edge_magnitude_core sem_checker u_sem_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_red_edge   (o_red_edge),
    .o_frame_last (o_frame_last)
);
`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench for the streaming RGB Sobel edge magnitude block.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CH_W        = sem_pkg::CH_W;
    localparam int CFG_W       = sem_pkg::CFG_W;
    localparam int IDX_W       = sem_pkg::IDX_W;
    localparam int PIX_W       = sem_pkg::PIX_W;
    localparam int LINE_DEPTH  = sem_pkg::DEF_MAX_WIDTH;
    localparam int FLUSH_WAIT  = 48;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int RAND_ITEMS  = 1200;
    localparam int SHOW_MAX    = 10;

    localparam int KX[9] = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
    localparam int KY[9] = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};

    // idle modes: nobody idles, sender idles, receiver stalls, both do a little
    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        logic            cmd;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pixel_req;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            last;
    } t_edge_res;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic                i_cmd;
    logic [CH_W-1:0]     i_red;
    logic [CH_W-1:0]     i_green;
    logic [CH_W-1:0]     i_blue;
    logic                o_valid;
    logic                i_stall;
    logic [CH_W-1:0]     o_red_edge;
    logic [CH_W-1:0]     o_green_edge;
    logic [CH_W-1:0]     o_blue_edge;
    logic                o_frame_last;
    logic                i_cfg_we;
    logic [IDX_W-1:0]    i_cfg_index;
    logic [CFG_W-1:0]    i_cfg_data;

    sobel_edge_magnitude_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cmd       (i_cmd),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_red_edge  (o_red_edge),
        .o_green_edge(o_green_edge),
        .o_blue_edge (o_blue_edge),
        .o_frame_last(o_frame_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    t_pixel_req   pending_reqs[$];
    t_edge_res    expected_edges[$];
    t_idle_mode   idle_mode;
    bit           req_taken;
    int           cycle_count;
    int           mismatch_count;
    int           rand_items;

    // shadow copy of the block: registers, line stores, window, raster counters
    logic [CFG_W-1:0]   img_w_reg;
    logic [CFG_W-1:0]   img_h_reg;
    logic [PIX_W-1:0]   upper_line[LINE_DEPTH];
    logic [PIX_W-1:0]   middle_line[LINE_DEPTH];
    logic [PIX_W-1:0]   frame_win[9];
    int                 in_row, in_col, out_row, out_col;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int clamp_dim(logic [CFG_W-1:0] v, int lim);
        if (v == 0) return 1;
        if (int'(v) > lim) return lim;
        return int'(v);
    endfunction

    function automatic logic [CH_W-1:0] rounded_root(int unsigned s);
        int unsigned q = 0;
        int unsigned t;
        if (s > 65280) return sem_pkg::MAG_MAX;
        for (int b = 7; b >= 0; b--) begin
            t = q | (1 << b);
            if (t * t <= s) q = t;
        end
        if (s > q * q + q) q++;
        if (q > 255) q = 255;
        return q[CH_W-1:0];
    endfunction

    // gradient magnitude of one channel over the taps that fall inside the image
    function automatic logic [CH_W-1:0] channel_edge(int lsb, logic [8:0] inside_img);
        int gx = 0;
        int gy = 0;
        int v;
        for (int k = 0; k < 9; k++) begin
            if (inside_img[k]) begin
                v = int'(frame_win[k][lsb +: CH_W]);
                gx += KX[k] * v;
                gy += KY[k] * v;
            end
        end
        return rounded_root(gx * gx + gy * gy);
    endfunction

    function automatic void restart_frame();
        foreach (frame_win[k]) frame_win[k] = '0;
        in_row  = 0;
        in_col  = 0;
        out_row = 0;
        out_col = 0;
    endfunction

    // advance the shadow raster by one accepted request, queue its result if any
    function automatic void predict_edges(t_pixel_req req);
        int               w;
        int               h;
        int               col;
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] mid;
        bit               emit;
        logic [8:0]       inside_img;
        t_edge_res        res;
        w   = clamp_dim(img_w_reg, sem_pkg::DEF_MAX_WIDTH);
        h   = clamp_dim(img_h_reg, sem_pkg::MAX_HEIGHT);
        col = (in_col >= w) ? w - 1 : in_col;
        px  = {req.red, req.green, req.blue};
        // drain ticks and pixels beyond the last row enter as black
        if (req.cmd || in_row >= h) px = '0;
        emit = (in_row >= 2) || (in_row == 1 && col >= 1);
        up  = upper_line[col];
        mid = middle_line[col];
        upper_line[col]  = mid;
        middle_line[col] = px;
        for (int r = 0; r < 3; r++) begin
            frame_win[r*3]   = frame_win[r*3+1];
            frame_win[r*3+1] = frame_win[r*3+2];
        end
        frame_win[2] = up;
        frame_win[5] = mid;
        frame_win[8] = px;
        in_col = col + 1;
        if (in_col >= w) begin
            in_col = 0;
            if (in_row < 2047) in_row++;
        end
        if (!emit) return;
        for (int k = 0; k < 9; k++) begin
            inside_img[k] = !((k / 3 == 0 && out_row == 0) || (k / 3 == 2 && out_row + 1 >= h)
                           || (k % 3 == 0 && out_col == 0) || (k % 3 == 2 && out_col + 1 >= w));
        end
        res.red   = channel_edge(16, inside_img);
        res.green = channel_edge(8, inside_img);
        res.blue  = channel_edge(0, inside_img);
        res.last  = (out_row + 1 >= h) && (out_col + 1 >= w);
        expected_edges.push_back(res);
        if (res.last) begin
            restart_frame();
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
    endfunction

    function automatic bit roll(int pct);
        return $urandom_range(99) < pct;
    endfunction

    // Driver: present the next request at the falling edge, hold it until taken.
    always @(negedge i_clk) begin
        if (!i_valid || req_taken) begin
            if (pending_reqs.size() > 0
                && !roll(idle_mode == IDLE_SEND ? 75 : idle_mode == IDLE_BOTH ? 19 : 0)) begin
                {i_cmd, i_red, i_green, i_blue} <= pending_reqs.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_stall <= roll(idle_mode == IDLE_RECV ? 75 : idle_mode == IDLE_BOTH ? 19 : 0);
    end

    // Monitor: sample handshakes at the rising edge, run the predictor, check results.
    always @(posedge i_clk) begin
        t_edge_res want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end else begin
            req_taken = i_rst_n && i_valid && !o_stall;
            if (i_rst_n && i_cfg_we) begin
                if (i_cfg_index == sem_pkg::REG_IMAGE_WIDTH) img_w_reg = i_cfg_data;
                else img_h_reg = i_cfg_data;
                restart_frame();
            end
            if (req_taken) predict_edges({i_cmd, i_red, i_green, i_blue});
            if (i_rst_n && o_valid && !i_stall) begin
                if (expected_edges.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= SHOW_MAX)
                        $display("unexpected result r=%0d g=%0d b=%0d last=%0b",
                                 o_red_edge, o_green_edge, o_blue_edge, o_frame_last);
                end else begin
                    want = expected_edges.pop_front();
                    if ({o_red_edge, o_green_edge, o_blue_edge, o_frame_last} !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= SHOW_MAX)
                            $display({"edge mismatch: expected r=%0d g=%0d b=%0d last=%0b,",
                                      " got r=%0d g=%0d b=%0d last=%0b"},
                                     want.red, want.green, want.blue, want.last,
                                     o_red_edge, o_green_edge, o_blue_edge, o_frame_last);
                    end
                end
            end
        end
    end

    task automatic write_reg(sem_pkg::t_reg_idx idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // hold until every request is taken and every result is back, then let the pipe settle
    task automatic wait_idle();
        while (pending_reqs.size() > 0 || i_valid || expected_edges.size() > 0)
            @(posedge i_clk);
        repeat (FLUSH_WAIT) @(posedge i_clk);
    endtask

    task automatic add_req(logic cmd, logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                           logic [CH_W-1:0] b);
        pending_reqs.push_back({cmd, r, g, b});
        rand_items++;
    endtask

    // one frame of random pixels followed by the drain requests;
    // a short drain leaves the frame open so the next one runs into it
    task automatic add_frame(int w, int h, bit short_drain);
        int drains;
        for (int p = 0; p < w * h; p++) begin
            if (roll(10)) add_req(1'b0, roll(50) ? 8'hFF : 8'h00, CH_W'($urandom),
                                  roll(50) ? 8'hFF : 8'h00);
            else add_req(1'b0, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
        end
        drains = short_drain ? $urandom_range(w) : w + 1;
        for (int d = 0; d < drains; d++) begin
            // some drains arrive as real pixels past the last row
            add_req(roll(20) ? 1'b0 : 1'b1, CH_W'($urandom), CH_W'($urandom),
                    CH_W'($urandom));
        end
    endtask

    task automatic set_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
        write_reg(sem_pkg::REG_IMAGE_WIDTH, w);
        write_reg(sem_pkg::REG_IMAGE_HEIGHT, h);
    endtask

    initial begin
        int w;
        int h;
        int phase;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_cmd       = 1'b0;
        i_red       = '0;
        i_green     = '0;
        i_blue      = '0;
        i_stall     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = sem_pkg::REG_IMAGE_WIDTH;
        i_cfg_data  = '0;
        idle_mode   = IDLE_NONE;
        req_taken   = 1'b0;
        cycle_count = 0;
        mismatch_count = 0;
        rand_items  = 0;
        img_w_reg   = sem_pkg::RESET_DIM;
        img_h_reg   = sem_pkg::RESET_DIM;
        foreach (upper_line[k]) begin
            upper_line[k]  = '0;
            middle_line[k] = '0;
        end
        restart_frame();
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed 3x3 frame: channel extremes, a pixel past the frame, drains
        set_size(3, 3);
        add_req(1'b0, 8'h00, 8'h00, 8'h00);
        add_req(1'b0, 8'hFF, 8'hFF, 8'hFF);
        add_req(1'b0, 8'hFF, 8'h00, 8'h00);
        add_req(1'b0, 8'h00, 8'hFF, 8'h00);
        add_req(1'b0, 8'h00, 8'h00, 8'hFF);
        add_req(1'b0, 8'hFF, 8'hFF, 8'hFF);
        add_req(1'b0, 8'h00, 8'h00, 8'h00);
        add_req(1'b0, 8'hFF, 8'hFF, 8'hFF);
        add_req(1'b0, 8'hAA, 8'h55, 8'h01);
        add_req(1'b0, 8'hFF, 8'hFF, 8'hFF);
        add_req(1'b1, 8'hFF, 8'hFF, 8'hFF);
        add_req(1'b1, 8'h00, 8'h00, 8'h00);
        add_req(1'b1, 8'hFF, 8'hFF, 8'hFF);
        wait_idle();

        // register extremes: zero acts as one, oversize clamps to the limits;
        // the oversize frame is cut short by the next register write
        idle_mode = IDLE_SEND;
        set_size(0, 0);
        add_frame(1, 1, 1'b0);
        wait_idle();
        idle_mode = IDLE_BOTH;
        set_size(11'd2047, 11'd2047);
        repeat (40) add_req(1'b0, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
        wait_idle();
        idle_mode = IDLE_RECV;
        set_size(2, 1);
        add_frame(2, 1, 1'b0);
        wait_idle();

        // random phases of small images, rotating the idle pattern
        rand_items = 0;
        phase = 0;
        while (rand_items < RAND_ITEMS) begin
            idle_mode = t_idle_mode'(phase % 4);
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            set_size(CFG_W'(w), CFG_W'(h));
            repeat ($urandom_range(1, 3)) add_frame(w, h, roll(10));
            // stray requests at the tail of a phase
            if (roll(15))
                repeat ($urandom_range(1, 4))
                    add_req(1'($urandom), CH_W'($urandom), CH_W'($urandom),
                            CH_W'($urandom));
            wait_idle();
            phase++;
        end

        wait_idle();
        if (mismatch_count == 0 && expected_edges.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
